// File: rtl/core/ps2kc_pkg.sv
package ps2kc_pkg;

   // Access kinds carried in req_tuser
   typedef enum logic [1:0] {
      FUNC_DATA_READ   = 2'd0,
      FUNC_STATUS_READ = 2'd1,
      FUNC_DATA_WRITE  = 2'd2,
      FUNC_CMD_WRITE   = 2'd3
   } func_type;

   localparam int RAM_DEPTH   = 31;
   localparam int RAM_AW      = $clog2(RAM_DEPTH);
   localparam int RSP_WIDTH   = 16;

   // Controller commands
   localparam logic [7:0] CMD_READ_CB      = 8'h20;
   localparam logic [7:0] CMD_READ_RAM_LO  = 8'h21;
   localparam logic [7:0] CMD_READ_RAM_HI  = 8'h3f;
   localparam logic [7:0] CMD_WRITE_CB     = 8'h60;
   localparam logic [7:0] CMD_WRITE_RAM_LO = 8'h61;
   localparam logic [7:0] CMD_WRITE_RAM_HI = 8'h7f;
   localparam logic [7:0] CMD_PASSWORD     = 8'ha4;
   localparam logic [7:0] CMD_MOUSE_OFF    = 8'ha7;
   localparam logic [7:0] CMD_MOUSE_ON     = 8'ha8;
   localparam logic [7:0] CMD_MOUSE_TEST   = 8'ha9;
   localparam logic [7:0] CMD_SELF_TEST    = 8'haa;
   localparam logic [7:0] CMD_KBD_TEST     = 8'hab;
   localparam logic [7:0] CMD_KBD_OFF      = 8'had;
   localparam logic [7:0] CMD_KBD_ON       = 8'hae;
   localparam logic [7:0] CMD_READ_OUTPORT = 8'hd0;
   localparam logic [7:0] CMD_WRITE_OUTPORT= 8'hd1;
   localparam logic [7:0] CMD_WRITE_OUTBUF = 8'hd2;
   localparam logic [7:0] CMD_A20_OFF      = 8'hdd;
   localparam logic [7:0] CMD_A20_ON       = 8'hde;
   localparam logic [7:0] CMD_READ_TESTIN  = 8'he0;
   localparam logic [7:0] CMD_PULSE_RESET  = 8'hfe;

   // Command replies
   localparam logic [7:0] RPL_PW_YES       = 8'hfa;
   localparam logic [7:0] RPL_PW_NO        = 8'hf1;
   localparam logic [7:0] RPL_MOUSE_OK     = 8'h01;
   localparam logic [7:0] RPL_SELF_OK      = 8'h55;
   localparam logic [7:0] RPL_KBD_OK       = 8'h00;

   // Bit positions within rsp_tdata
   localparam int RSP_IRQ_BIT   = 8;
   localparam int RSP_A20_BIT   = 9;
   localparam int RSP_RESET_BIT = 10;

endpackage

// File: rtl/core/ps2kc_skid.sv
module ps2kc_skid #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic             out_valid_ff, out_valid_in;
   logic [WIDTH-1:0] out_data_ff, out_data_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [WIDTH-1:0] skid_data_ff, skid_data_in;
   logic             in_fire;

   assign in_ready  = !skid_valid_ff;
   assign in_fire   = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (in_fire) begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (in_fire) begin
         // output stalled: park the word
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// File: rtl/core/ps2_keyboard_controller_ports.sv
// Keyboard controller, processor side: one bus access per word.
// A result is registered: rsp_tvalid rises in the cycle after accept when the output is free.
// Throughput: 1 word per cycle while rsp_tready is high; a two-entry output stage absorbs one stalled result.
// Reset (synchronous): status 0x04, command byte, RAM, lines and buffers cleared,
// password flag cleared, output stage emptied.
module ps2_keyboard_controller_ports
   import ps2kc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] write_byte
   input  logic [1:0]  req_tuser,   // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] read_byte, [8] irq_request,
                                    // [9] a20_enable, [10] cpu_reset_request
   input  logic        csr_we,
   input  logic        csr_wdata
);

   logic       password_ff;
   logic       obf_ff, obf_in;
   logic       cmd_last_ff, cmd_last_in;
   logic [7:0] cb_ff, cb_in;
   logic [7:0] pend_ff, pend_in;
   logic [7:0] ob_ff, ob_in;
   logic       a20_ff, a20_in;
   logic       rst_line_ff, rst_line_in;
   logic       kdata_ff, kdata_in;
   logic       kclk_ff, kclk_in;
   logic [7:0] ram_ff [RAM_DEPTH];

   logic              ram_we;
   logic [RAM_AW-1:0] ram_waddr;
   logic [RAM_AW-1:0] ram_raddr;
   logic [7:0]        ram_wdata;

   logic       req_fire;
   func_type   func;
   logic [7:0] wbyte;
   logic [7:0] status;
   logic [7:0] rd_byte;
   logic       ld;
   logic [7:0] ld_val;
   logic       irq;
   logic [RSP_WIDTH-1:0] rsp_word;

   assign req_fire  = req_tvalid && req_tready;
   assign func      = func_type'(req_tuser);
   assign wbyte     = req_tdata;
   assign status    = {4'b0000, cmd_last_ff, 1'b1, 1'b0, obf_ff};
   assign ram_raddr = wbyte[RAM_AW-1:0] - RAM_AW'(1);

   always_comb begin
      obf_in      = obf_ff;
      cmd_last_in = cmd_last_ff;
      cb_in       = cb_ff;
      pend_in     = pend_ff;
      ob_in       = ob_ff;
      a20_in      = a20_ff;
      rst_line_in = rst_line_ff;
      kdata_in    = kdata_ff;
      kclk_in     = kclk_ff;
      ram_we      = 1'b0;
      ram_waddr   = pend_ff[RAM_AW-1:0] - RAM_AW'(1);
      ram_wdata   = wbyte;
      rd_byte     = 8'h00;
      ld          = 1'b0;
      ld_val      = 8'h00;
      case (func)
         FUNC_DATA_READ: begin
            rd_byte = ob_ff;
            obf_in  = 1'b0;
         end
         FUNC_STATUS_READ: begin
            rd_byte = status;
         end
         FUNC_DATA_WRITE: begin
            if (cmd_last_ff) begin
               if (pend_ff == CMD_WRITE_CB) begin
                  cb_in = wbyte;
               end else if (pend_ff inside {[CMD_WRITE_RAM_LO:CMD_WRITE_RAM_HI]}) begin
                  ram_we = 1'b1;
               end else if (pend_ff == CMD_WRITE_OUTPORT) begin
                  kdata_in    = wbyte[7];
                  kclk_in     = wbyte[6];
                  a20_in      = wbyte[1];
                  rst_line_in = wbyte[0];
                  if (wbyte[4]) begin
                     ld     = 1'b1;
                     ld_val = ob_ff;
                  end
               end else if (pend_ff == CMD_WRITE_OUTBUF) begin
                  ld     = 1'b1;
                  ld_val = wbyte;
               end
            end
            pend_in     = wbyte;
            cmd_last_in = 1'b0;
         end
         FUNC_CMD_WRITE: begin
            pend_in     = wbyte;
            cmd_last_in = 1'b1;
            if (wbyte == CMD_READ_CB) begin
               ld     = 1'b1;
               ld_val = cb_ff;
            end else if (wbyte inside {[CMD_READ_RAM_LO:CMD_READ_RAM_HI]}) begin
               ld     = 1'b1;
               ld_val = ram_ff[ram_raddr];
            end else begin
               case (wbyte)
                  CMD_PASSWORD: begin
                     ld     = 1'b1;
                     ld_val = password_ff ? RPL_PW_YES : RPL_PW_NO;
                  end
                  CMD_MOUSE_OFF:  cb_in = cb_ff | 8'h20;
                  CMD_MOUSE_ON:   cb_in = cb_ff & 8'hdf;
                  CMD_MOUSE_TEST: begin
                     ld     = 1'b1;
                     ld_val = RPL_MOUSE_OK;
                  end
                  CMD_SELF_TEST: begin
                     ld     = 1'b1;
                     ld_val = RPL_SELF_OK;
                  end
                  CMD_KBD_TEST: begin
                     ld     = 1'b1;
                     ld_val = RPL_KBD_OK;
                  end
                  CMD_KBD_OFF:    cb_in = cb_ff | 8'h10;
                  CMD_KBD_ON:     cb_in = cb_ff & 8'hef;
                  CMD_READ_OUTPORT: begin
                     ld     = 1'b1;
                     ld_val = {kdata_ff, kclk_ff, 1'b0, 1'b1, 2'b00, a20_ff, rst_line_ff};
                  end
                  CMD_A20_OFF:    a20_in = 1'b0;
                  CMD_A20_ON:     a20_in = 1'b1;
                  CMD_READ_TESTIN: begin
                     ld     = 1'b1;
                     ld_val = {6'b000000, kdata_ff, kclk_ff};
                  end
                  CMD_PULSE_RESET: rst_line_in = 1'b1;
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      if (ld) begin
         ob_in  = ld_val;
         obf_in = 1'b1;
      end
   end

   // IRQ follows the command byte as it stands before this access
   assign irq      = ld && cb_ff[0];
   assign rsp_word = {5'b00000, rst_line_in, a20_in, irq, rd_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         password_ff <= 1'b0;
         obf_ff      <= 1'b0;
         cmd_last_ff <= 1'b0;
         cb_ff       <= 8'h00;
         pend_ff     <= 8'h00;
         ob_ff       <= 8'h00;
         a20_ff      <= 1'b0;
         rst_line_ff <= 1'b0;
         kdata_ff    <= 1'b0;
         kclk_ff     <= 1'b0;
         for (int i = 0; i < RAM_DEPTH; i++) begin
            ram_ff[i] <= 8'h00;
         end
      end else begin
         if (csr_we) begin
            password_ff <= csr_wdata;
         end
         if (req_fire) begin
            obf_ff      <= obf_in;
            cmd_last_ff <= cmd_last_in;
            cb_ff       <= cb_in;
            pend_ff     <= pend_in;
            ob_ff       <= ob_in;
            a20_ff      <= a20_in;
            rst_line_ff <= rst_line_in;
            kdata_ff    <= kdata_in;
            kclk_ff     <= kclk_in;
            if (ram_we) begin
               ram_ff[ram_waddr] <= ram_wdata;
            end
         end
      end
   end

   ps2kc_skid #(
      .WIDTH(RSP_WIDTH)
   ) u_skid (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_data  (rsp_word),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (rsp_tdata)
   );

endmodule

// File: rtl/core/ps2kc_checker.sv
module ps2kc_checker
   import ps2kc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output stage is empty");

   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> rsp_tvalid)
      else $error("result missing one cycle after accept");

   // IRQ only comes from writes, and writes return a zero byte
   a_irq_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_IRQ_BIT] |-> rsp_tdata[7:0] == 8'h00)
      else $error("irq on a read access");

endmodule

bind ps2_keyboard_controller_ports ps2kc_checker u_checker (.*);

// File: sim/ps2_keyboard_controller_ports_test.sv
`timescale 1ns / 100ps

module ps2_keyboard_controller_ports_test;
   import ps2kc_pkg::*;

   localparam logic [7:0] STATUS_RESET = 8'h04;
   localparam int         ST_OBF       = 0;
   localparam int         ST_CMD       = 3;
   localparam int         CB_IRQ       = 0;
   localparam int         HOLD_CYCLES  = 60;
   localparam int         DRAIN_CYCLES = 8;
   localparam int         PHASE_WORDS  = 350;

   typedef struct packed {
      func_type   func;
      logic [7:0] wbyte;
      logic       pinned;      // read_byte below is typed in, not predicted
      logic [7:0] pinned_rd;
   } access_row;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       irq;
      logic       a20;
      logic       cpu_rst;
   } kbc_reply;

   localparam int DIR_ROWS = 26;
   localparam access_row DIR_TABLE [DIR_ROWS] = '{
      '{FUNC_STATUS_READ, 8'h00,             1'b1, STATUS_RESET},
      '{FUNC_DATA_READ,   8'h00,             1'b1, 8'h00},
      '{FUNC_CMD_WRITE,   CMD_SELF_TEST,     1'b1, 8'h00},
      '{FUNC_DATA_READ,   8'hff,             1'b1, RPL_SELF_OK},
      '{FUNC_CMD_WRITE,   CMD_PASSWORD,      1'b1, 8'h00},
      '{FUNC_DATA_READ,   8'h00,             1'b1, RPL_PW_NO},
      '{FUNC_CMD_WRITE,   CMD_MOUSE_TEST,    1'b1, 8'h00},
      '{FUNC_DATA_READ,   8'h00,             1'b1, RPL_MOUSE_OK},
      '{FUNC_CMD_WRITE,   CMD_PULSE_RESET,   1'b0, 8'h00},
      '{FUNC_CMD_WRITE,   CMD_WRITE_CB,      1'b0, 8'h00},
      '{FUNC_DATA_WRITE,  8'hff,             1'b0, 8'h00},
      '{FUNC_CMD_WRITE,   CMD_READ_CB,       1'b0, 8'h00},
      '{FUNC_CMD_WRITE,   CMD_WRITE_RAM_HI,  1'b0, 8'h00},
      '{FUNC_DATA_WRITE,  8'ha5,             1'b0, 8'h00},
      '{FUNC_CMD_WRITE,   CMD_READ_RAM_HI,   1'b0, 8'h00},
      '{FUNC_DATA_READ,   8'h00,             1'b0, 8'h00},
      '{FUNC_CMD_WRITE,   CMD_READ_RAM_LO,   1'b0, 8'h00},
      '{FUNC_CMD_WRITE,   CMD_WRITE_OUTPORT, 1'b0, 8'h00},
      '{FUNC_DATA_WRITE,  8'hff,             1'b0, 8'h00},
      '{FUNC_CMD_WRITE,   CMD_READ_OUTPORT,  1'b0, 8'h00},
      '{FUNC_CMD_WRITE,   CMD_READ_TESTIN,   1'b0, 8'h00},
      '{FUNC_CMD_WRITE,   CMD_A20_OFF,       1'b0, 8'h00},
      '{FUNC_CMD_WRITE,   CMD_WRITE_OUTBUF,  1'b0, 8'h00},
      '{FUNC_DATA_WRITE,  8'h00,             1'b0, 8'h00},
      '{FUNC_DATA_WRITE,  8'h5a,             1'b0, 8'h00},
      '{FUNC_STATUS_READ, 8'h00,             1'b0, 8'h00}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_we;
   logic        csr_wdata;

   ps2_keyboard_controller_ports u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // controller state as predicted
   logic [7:0] status_q;
   logic [7:0] cmd_byte_q;
   logic [7:0] ram_q [1:31];
   logic [7:0] last_cmd_q;
   logic [7:0] outbuf_q;
   logic       a20_q;
   logic       rst_line_q;
   logic       kdata_q;
   logic       kclk_q;
   logic       password_q;

   kbc_reply   expected_replies [$];
   int         mismatch_count;
   logic       drv_pinned;
   logic [7:0] drv_pinned_rd;
   int         burst_left;
   logic       hold_off_req;
   logic       hold_off_done;

   function automatic logic load_outbuf(input logic [7:0] v);
      outbuf_q         = v;
      status_q[ST_OBF] = 1'b1;
      return cmd_byte_q[CB_IRQ];
   endfunction

   task automatic kbc_access(input func_type f, input logic [7:0] b, output kbc_reply r);
      logic       irq;
      logic [7:0] rd;
      irq = 1'b0;
      rd  = 8'h00;
      case (f)
         FUNC_DATA_READ: begin
            rd               = outbuf_q;
            status_q[ST_OBF] = 1'b0;
         end
         FUNC_STATUS_READ: rd = status_q;
         FUNC_DATA_WRITE: begin
            // the byte is an argument only when the last write was a command
            if (status_q[ST_CMD]) begin
               if (last_cmd_q == CMD_WRITE_CB) begin
                  cmd_byte_q = b;
               end else if (last_cmd_q >= CMD_WRITE_RAM_LO && last_cmd_q <= CMD_WRITE_RAM_HI) begin
                  ram_q[last_cmd_q - CMD_WRITE_CB] = b;
               end else if (last_cmd_q == CMD_WRITE_OUTPORT) begin
                  kdata_q = b[7];
                  kclk_q  = b[6];
                  if (b[4]) irq = load_outbuf(outbuf_q);
                  a20_q      = b[1];
                  rst_line_q = b[0];
               end else if (last_cmd_q == CMD_WRITE_OUTBUF) begin
                  irq = load_outbuf(b);
               end
            end
            last_cmd_q       = b;
            status_q[ST_CMD] = 1'b0;
         end
         default: begin
            last_cmd_q       = b;
            status_q[ST_CMD] = 1'b1;
            if (b == CMD_READ_CB) begin
               irq = load_outbuf(cmd_byte_q);
            end else if (b >= CMD_READ_RAM_LO && b <= CMD_READ_RAM_HI) begin
               irq = load_outbuf(ram_q[b - CMD_READ_CB]);
            end else begin
               case (b)
                  CMD_PASSWORD:     irq = load_outbuf(password_q ? RPL_PW_YES : RPL_PW_NO);
                  CMD_MOUSE_OFF:    cmd_byte_q[5] = 1'b1;
                  CMD_MOUSE_ON:     cmd_byte_q[5] = 1'b0;
                  CMD_MOUSE_TEST:   irq = load_outbuf(RPL_MOUSE_OK);
                  CMD_SELF_TEST:    irq = load_outbuf(RPL_SELF_OK);
                  CMD_KBD_TEST:     irq = load_outbuf(RPL_KBD_OK);
                  CMD_KBD_OFF:      cmd_byte_q[4] = 1'b1;
                  CMD_KBD_ON:       cmd_byte_q[4] = 1'b0;
                  CMD_READ_OUTPORT: irq = load_outbuf({kdata_q, kclk_q, 2'b01, 2'b00,
                                                       a20_q, rst_line_q});
                  CMD_A20_OFF:      a20_q = 1'b0;
                  CMD_A20_ON:       a20_q = 1'b1;
                  CMD_READ_TESTIN:  irq = load_outbuf({6'b0, kdata_q, kclk_q});
                  CMD_PULSE_RESET:  rst_line_q = 1'b1;
                  default: ;
               endcase
            end
         end
      endcase
      r.read_byte = rd;
      r.irq       = irq;
      r.a20       = a20_q;
      r.cpu_rst   = rst_line_q;
   endtask

   task automatic report_mismatch(input string field, input int got, input int want);
      if (mismatch_count < 30)
         $display("%0t: %s mismatch: got %02h, want %02h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   // predict on accept, check on result
   always @(posedge clock) begin
      kbc_reply pred;
      kbc_reply want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            kbc_access(func_type'(req_tuser), req_tdata, pred);
            if (drv_pinned) pred.read_byte = drv_pinned_rd;
            expected_replies.push_back(pred);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata, 0);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_tdata[7:0] !== want.read_byte)
                  report_mismatch("read_byte", rsp_tdata[7:0], want.read_byte);
               if (rsp_tdata[RSP_IRQ_BIT] !== want.irq)
                  report_mismatch("irq_request", rsp_tdata[RSP_IRQ_BIT], want.irq);
               if (rsp_tdata[RSP_A20_BIT] !== want.a20)
                  report_mismatch("a20_enable", rsp_tdata[RSP_A20_BIT], want.a20);
               if (rsp_tdata[RSP_RESET_BIT] !== want.cpu_rst)
                  report_mismatch("cpu_reset_request", rsp_tdata[RSP_RESET_BIT], want.cpu_rst);
            end
         end
      end
   end

   // receiver: segments of steady, random, sparse and alternating ready
   initial begin
      int mode;
      int seg;
      rsp_tready    = 1'b0;
      hold_off_done = 1'b0;
      wait (reset === 1'b0);
      forever begin
         mode = $urandom_range(0, 3);
         seg  = $urandom_range(10, 80);
         for (int i = 0; i < seg; i++) begin
            @(negedge clock);
            if (hold_off_req && !hold_off_done) begin
               // hold off long enough for the block to back up its input
               rsp_tready = 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
               hold_off_done = 1'b1;
            end
            case (mode)
               0:       rsp_tready = 1'b1;
               1:       rsp_tready = $urandom_range(0, 1);
               2:       rsp_tready = ($urandom_range(0, 3) == 0);
               default: rsp_tready = i[0];
            endcase
         end
      end
   end

   task automatic send_access(input access_row row);
      @(negedge clock);
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid    = 1'b1;
      req_tuser     = row.func;
      req_tdata     = row.wbyte;
      drv_pinned    = row.pinned;
      drv_pinned_rd = row.pinned_rd;
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   task automatic write_password(input logic v);
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_replies.size() != 0) @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_we     = 1'b0;
      password_q = v;
   endtask

   function automatic access_row mk(input func_type f, input logic [7:0] b);
      return '{f, b, 1'b0, 8'h00};
   endfunction

   // mostly well-formed command sequences, some noise and dangling commands
   task automatic run_mixed_traffic(input int count);
      access_row  seq [$];
      logic [7:0] c;
      int         sent;
      int         pick;
      logic       takes_arg;
      sent = 0;
      while (sent < count) begin
         seq.delete();
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            seq.push_back(mk(func_type'($urandom_range(0, 3)), 8'($urandom)));
         end else begin
            takes_arg = 1'b0;
            case ($urandom_range(0, 11))
               0:  c = CMD_READ_CB;
               1:  c = 8'($urandom_range(CMD_READ_RAM_LO, CMD_READ_RAM_HI));
               2:  begin c = CMD_WRITE_CB; takes_arg = 1'b1; end
               3:  begin
                      c = 8'($urandom_range(CMD_WRITE_RAM_LO, CMD_WRITE_RAM_HI));
                      takes_arg = 1'b1;
                   end
               4:  c = CMD_PASSWORD;
               5:  case ($urandom_range(0, 3))
                      0: c = CMD_MOUSE_OFF;
                      1: c = CMD_MOUSE_ON;
                      2: c = CMD_KBD_OFF;
                      default: c = CMD_KBD_ON;
                   endcase
               6:  case ($urandom_range(0, 2))
                      0: c = CMD_MOUSE_TEST;
                      1: c = CMD_SELF_TEST;
                      default: c = CMD_KBD_TEST;
                   endcase
               7:  c = $urandom_range(0, 1) ? CMD_READ_OUTPORT : CMD_READ_TESTIN;
               8:  begin c = CMD_WRITE_OUTPORT; takes_arg = 1'b1; end
               9:  begin c = CMD_WRITE_OUTBUF; takes_arg = 1'b1; end
               10: case ($urandom_range(0, 2))
                      0: c = CMD_A20_OFF;
                      1: c = CMD_A20_ON;
                      default: c = CMD_PULSE_RESET;
                   endcase
               default: c = 8'($urandom);
            endcase
            seq.push_back(mk(FUNC_CMD_WRITE, c));
            // drop the argument now and then to leave the command dangling
            if (takes_arg && pick >= 20)
               seq.push_back(mk(FUNC_DATA_WRITE, 8'($urandom)));
            if ($urandom_range(0, 9) < 6)
               seq.push_back(mk(FUNC_DATA_READ, 8'($urandom)));
            if ($urandom_range(0, 9) < 3)
               seq.push_back(mk(FUNC_STATUS_READ, 8'($urandom)));
         end
         foreach (seq[i]) send_access(seq[i]);
         sent += seq.size();
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = 8'h00;
      req_tuser      = FUNC_DATA_READ;
      csr_we         = 1'b0;
      csr_wdata      = 1'b0;
      drv_pinned     = 1'b0;
      drv_pinned_rd  = 8'h00;
      burst_left     = 0;
      hold_off_req   = 1'b0;
      mismatch_count = 0;
      status_q       = STATUS_RESET;
      cmd_byte_q     = 8'h00;
      last_cmd_q     = 8'h00;
      outbuf_q       = 8'h00;
      a20_q          = 1'b0;
      rst_line_q     = 1'b0;
      kdata_q        = 1'b0;
      kclk_q         = 1'b0;
      password_q     = 1'b0;
      foreach (ram_q[i]) ram_q[i] = 8'h00;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      write_password(1'b0);
      for (int i = 0; i < DIR_ROWS; i++) send_access(DIR_TABLE[i]);

      for (int ph = 0; ph < 4; ph++) begin
         write_password(ph[0] ? 1'b0 : 1'b1);
         if (ph == 0) begin
            hold_off_req = 1'b1;
            burst_left   = 150;
         end
         run_mixed_traffic(PHASE_WORDS);
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
